FILE: rtl/qcd_pkg.sv
// Package for the QOI chunk decoder: chunk tags, opcodes, sequencer states
// and the color index hash. No dependencies.
package qcd_pkg;

	localparam int PIX_W   = 32;
	localparam int TOTAL_W = 29;
	localparam int SLOT_W  = 6;
	localparam int RUN_W   = 6;

	localparam logic [7:0] TAG_RGB  = 8'hFE;
	localparam logic [7:0] TAG_RGBA = 8'hFF;

	localparam logic [1:0] OP_INDEX = 2'd0;
	localparam logic [1:0] OP_DIFF  = 2'd1;
	localparam logic [1:0] OP_LUMA  = 2'd2;
	localparam logic [1:0] OP_RUN   = 2'd3;

	localparam logic [2:0] PH_TAG  = 3'd0;
	localparam logic [2:0] PH_B1   = 3'd1;
	localparam logic [2:0] PH_B2   = 3'd2;
	localparam logic [2:0] PH_B3   = 3'd3;
	localparam logic [2:0] PH_B4   = 3'd4;

	localparam logic [PIX_W-1:0] PIX_BLACK = 32'h0000_00FF;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_RUN
	} qcd_state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_EMIT,
		ACT_READ,
		ACT_RUN
	} qcd_act_t;

	// Index slot of a pixel: (3r + 5g + 7b + 11a) mod 64.
	function automatic logic [SLOT_W-1:0] slot_hash(input pixel_t px);
		logic [11:0] sum;
		sum = 12'(px[31:24]) * 12'd3 + 12'(px[23:16]) * 12'd5
			+ 12'(px[15:8]) * 12'd7 + 12'(px[7:0]) * 12'd11;
		return sum[SLOT_W-1:0];
	endfunction

endpackage

FILE: rtl/qcd_byte_if.sv
// Channel carrying chunk bytes into the QOI chunk decoder.
// Valid/ready handshake; no dependencies.
interface qcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_image;

	modport source (output valid, output data_byte, output start_image, input ready);
	modport sink (input valid, input data_byte, input start_image, output ready);
endinterface

FILE: rtl/qcd_pixel_if.sv
// Channel carrying decoded RGBA pixels out of the QOI chunk decoder.
// Valid/ready handshake; no dependencies.
interface qcd_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       run_last;
	logic       image_last;

	modport source (output valid, output red, output green, output blue, output alpha,
		output run_last, output image_last, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input run_last, input image_last, output ready);
endinterface

FILE: rtl/qoi_chunk_decoder.sv
// QOI chunk decoder top level: byte parser, color index memory and pixel output.
// Depends on qcd_pkg, qcd_byte_if and qcd_pixel_if.
//
//   channel    dir  payload                                    transfer when
//   byte_ch    in   data_byte[7:0], start_image                valid & ready
//   pixel_ch   out  red, green, blue, alpha, run_last,         valid & ready
//                   image_last
//   cfg        in   cfg_wdata[28:0] (pixel_total)              cfg_we
//
// A byte that only completes part of a chunk leaves the sequencer in ST_IDLE. RGB,
// RGBA, DIFF and LUMA chunks go to ST_EMIT, INDEX through ST_READ first for the
// registered read of the index memory. A RUN emits its n pixels from ST_RUN.
// The output register lets the next byte transfer while a pixel waits; stalls
// on pixel_ch hold the sequencer. Reset is asynchronous; the index needs no
// clearing pass since each entry has a valid bit.
module qoi_chunk_decoder import qcd_pkg::*; #(
	parameter int INDEX_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	qcd_byte_if.sink            byte_ch,
	qcd_pixel_if.source         pixel_ch,
	input  logic                cfg_we,
	input  logic [TOTAL_W-1:0]  cfg_wdata
);

	localparam int IDX_AW = $clog2(INDEX_ENTRIES);

	qcd_state_t          state_q, state_nx;
	qcd_act_t            act;

	logic [TOTAL_W-1:0]  total_q;
	pixel_t              prev_q;
	logic [TOTAL_W-1:0]  left_q;
	logic [2:0]          phase_q;
	logic [7:0]          tag_q;
	logic [23:0]         partial_q;
	pixel_t              pix_q;
	logic [RUN_W-1:0]    cnt_q;
	logic [IDX_AW-1:0]   rd_addr_q;
	logic [INDEX_ENTRIES-1:0] valid_q;
	logic [INDEX_ENTRIES-1:0] valid_nx;

	pixel_t              mem [INDEX_ENTRIES];
	pixel_t              rdata_q;
	logic                mem_we;
	logic [IDX_AW-1:0]   mem_waddr;
	pixel_t              mem_wdata;
	logic [SLOT_W-1:0]   pix_slot;
	logic [SLOT_W-1:0]   prev_slot;

	logic                out_valid_q;
	pixel_t              out_pix_q;
	logic                out_run_last_q;
	logic                out_image_last_q;

	logic                take;
	logic                out_free;
	logic                emit_fire;
	logic                run_fire;

	logic [7:0]          b;
	logic                start;
	pixel_t              eff_prev;
	logic [TOTAL_W-1:0]  eff_left;
	logic [2:0]          eff_phase;
	logic [7:0]          eff_tag;
	logic [23:0]         eff_partial;
	logic [2:0]          nx_phase;
	logic [7:0]          nx_tag;
	logic [23:0]         nx_partial;
	pixel_t              new_px;
	logic [RUN_W:0]      run_len;
	logic [RUN_W-1:0]    run_n;
	logic [7:0]          dgb;
	logic [7:0]          pr, pg, pb, pa;

	assign b      = byte_ch.data_byte;
	assign start  = byte_ch.start_image;
	assign take   = byte_ch.valid && byte_ch.ready;
	assign out_free  = !out_valid_q || pixel_ch.ready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign run_fire  = (state_q == ST_RUN) && out_free;
	assign pix_slot  = slot_hash(pix_q);
	assign prev_slot = slot_hash(eff_prev);

	// Chunk decode of the byte offered in the idle state.
	always_comb begin
		eff_prev    = start ? PIX_BLACK : prev_q;
		eff_left    = start ? total_q : left_q;
		eff_phase   = start ? PH_TAG : phase_q;
		eff_tag     = start ? 8'd0 : tag_q;
		eff_partial = start ? 24'd0 : partial_q;
		pr = eff_prev[31:24];
		pg = eff_prev[23:16];
		pb = eff_prev[15:8];
		pa = eff_prev[7:0];
		dgb = {2'b00, eff_tag[5:0]};
		nx_phase   = eff_phase;
		nx_tag     = eff_tag;
		nx_partial = eff_partial;
		new_px     = eff_prev;
		act        = ACT_NONE;
		run_len    = {1'b0, b[5:0]} + 7'd1;
		if (eff_left < TOTAL_W'(run_len)) begin
			run_n = eff_left[RUN_W-1:0];
		end else begin
			run_n = run_len[RUN_W-1:0];
		end
		if (eff_left == '0) begin
			nx_phase = PH_TAG;
		end else if (eff_phase == PH_TAG) begin
			if (b == TAG_RGB || b == TAG_RGBA || b[7:6] == OP_LUMA) begin
				nx_tag     = b;
				nx_phase   = PH_B1;
				nx_partial = '0;
			end else begin
				case (b[7:6])
					OP_INDEX: act = ACT_READ;
					OP_DIFF: begin
						act = ACT_EMIT;
						new_px = {pr + 8'(b[5:4]) - 8'd2, pg + 8'(b[3:2]) - 8'd2,
							pb + 8'(b[1:0]) - 8'd2, pa};
					end
					default: act = ACT_RUN;
				endcase
			end
		end else if (eff_tag == TAG_RGB || eff_tag == TAG_RGBA) begin
			case (eff_phase)
				PH_B1: begin
					nx_partial = {b, 16'd0};
					nx_phase   = PH_B2;
				end
				PH_B2: begin
					nx_partial = {eff_partial[23:16], b, 8'd0};
					nx_phase   = PH_B3;
				end
				PH_B3: begin
					nx_partial = {eff_partial[23:8], b};
					if (eff_tag == TAG_RGB) begin
						nx_phase = PH_TAG;
						act      = ACT_EMIT;
						new_px   = {eff_partial[23:8], b, pa};
					end else begin
						nx_phase = PH_B4;
					end
				end
				default: begin
					nx_phase = PH_TAG;
					act      = ACT_EMIT;
					new_px   = {eff_partial, b};
				end
			endcase
		end else begin
			// Second byte of a LUMA chunk; the green difference is biased by 32.
			nx_phase = PH_TAG;
			act      = ACT_EMIT;
			new_px   = {pr + dgb + 8'(b[7:4]) - 8'd40, pg + dgb - 8'd32,
				pb + dgb + 8'(b[3:0]) - 8'd40, pa};
		end
	end

	// Sequencer next state and memory write port.
	always_comb begin
		state_nx       = state_q;
		byte_ch.ready  = 1'b0;
		mem_we         = 1'b0;
		mem_waddr      = pix_slot[IDX_AW-1:0];
		mem_wdata      = pix_q;
		case (state_q)
			ST_IDLE: begin
				byte_ch.ready = 1'b1;
				if (byte_ch.valid) begin
					case (act)
						ACT_EMIT: state_nx = ST_EMIT;
						ACT_READ: state_nx = ST_READ;
						ACT_RUN: begin
							state_nx  = ST_RUN;
							mem_we    = 1'b1;
							mem_waddr = prev_slot[IDX_AW-1:0];
							mem_wdata = eff_prev;
						end
						default: state_nx = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					mem_we   = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (out_free && cnt_q == RUN_W'(1)) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// A start of image clears every valid bit; a write in the same cycle sets its own again.
	always_comb begin
		valid_nx = valid_q;
		if (take && start) begin
			valid_nx = '0;
		end
		if (mem_we) begin
			valid_nx[mem_waddr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Index memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[b[IDX_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= TOTAL_W'(1);
			prev_q    <= PIX_BLACK;
			left_q    <= '0;
			phase_q   <= PH_TAG;
			tag_q     <= '0;
			partial_q <= '0;
			valid_q   <= '0;
			cnt_q     <= '0;
			rd_addr_q <= '0;
			pix_q     <= '0;
		end else begin
			valid_q <= valid_nx;
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (take) begin
				prev_q    <= eff_prev;
				left_q    <= eff_left;
				phase_q   <= nx_phase;
				tag_q     <= nx_tag;
				partial_q <= nx_partial;
				rd_addr_q <= b[IDX_AW-1:0];
				pix_q     <= new_px;
				cnt_q     <= run_n;
			end
			if (state_q == ST_READ) begin
				pix_q <= valid_q[rd_addr_q] ? rdata_q : '0;
			end
			if (emit_fire) begin
				prev_q <= pix_q;
				left_q <= left_q - TOTAL_W'(1);
			end
			if (run_fire) begin
				left_q <= left_q - TOTAL_W'(1);
				cnt_q  <= cnt_q - RUN_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire || run_fire) begin
			out_valid_q <= 1'b1;
		end else if (pixel_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_pix_q        <= pix_q;
			out_run_last_q   <= 1'b1;
			out_image_last_q <= (left_q == TOTAL_W'(1));
		end else if (run_fire) begin
			out_pix_q        <= prev_q;
			out_run_last_q   <= (cnt_q == RUN_W'(1));
			out_image_last_q <= (left_q == TOTAL_W'(1));
		end
	end

	assign pixel_ch.valid      = out_valid_q;
	assign pixel_ch.red        = out_pix_q[31:24];
	assign pixel_ch.green      = out_pix_q[23:16];
	assign pixel_ch.blue       = out_pix_q[15:8];
	assign pixel_ch.alpha      = out_pix_q[7:0];
	assign pixel_ch.run_last   = out_run_last_q;
	assign pixel_ch.image_last = out_image_last_q;

endmodule
